// File: design/sprite_blit_word_rop_assert.svh
// Assertion macros shared by the sprite blit word raster-op design.
`ifndef SPRITE_BLIT_WORD_ROP_ASSERT_SVH
`define SPRITE_BLIT_WORD_ROP_ASSERT_SVH

// Same-cycle implication, checked on every aclk edge outside reset.
`define SBWR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every aclk edge outside reset.
`define SBWR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sbwr_pkg.sv
// Types, constants and helper functions for the sprite blit word raster-op block.
package sbwr_pkg;

    localparam int WORD_BITS = 32;
    localparam int COL_BITS  = $clog2(WORD_BITS);

    localparam logic [WORD_BITS-1:0] FULL_WORD  = 32'hFFFF_FFFF;
    localparam logic [WORD_BITS-1:0] LOW31_MASK = 32'h7FFF_FFFF;

    // Configuration register indexes (byte address = 4 * index)
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_RASTER_MODE     = 2'd0;
    localparam reg_idx_t REG_USE_SOURCE_MASK = 2'd1;
    localparam reg_idx_t REG_USE_DEST_MASK   = 2'd2;

    typedef enum logic [2:0] {
        ROP_COPY          = 3'd0,
        ROP_INVERT        = 3'd1,
        ROP_XOR           = 3'd2,
        ROP_XNOR          = 3'd3,
        ROP_SET_ALL       = 3'd4,
        ROP_SET_WHERE_SRC = 3'd5,
        ROP_CLEAR_ALL     = 3'd6,
        ROP_CLEAR_NOT_SRC = 3'd7
    } rop_mode_t;

    typedef struct packed {
        rop_mode_t raster_mode;
        logic      use_source_mask;
        logic      use_dest_mask;
    } sbwr_cfg_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] source_word_left;
        logic [WORD_BITS-1:0] source_word_right;
        logic [WORD_BITS-1:0] source_mask_left;
        logic [WORD_BITS-1:0] source_mask_right;
        logic [COL_BITS-1:0]  shift_amount;
        logic [WORD_BITS-1:0] dest_word;
        logic [WORD_BITS-1:0] dest_mask_word;
        logic [WORD_BITS-1:0] pattern_word;
        logic                 is_first_word;
        logic                 is_last_word;
        logic [COL_BITS-1:0]  left_column;
        logic [COL_BITS-1:0]  right_column;
    } sbwr_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] new_dest_word;
        logic [WORD_BITS-1:0] new_dest_mask_word;
        logic                 write_enable;
    } sbwr_out_t;

    function automatic logic [WORD_BITS-1:0] swap_bytes(input logic [WORD_BITS-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Low word of {left, right} shifted right by s
    function automatic logic [WORD_BITS-1:0] funnel(input logic [WORD_BITS-1:0] left,
                                                    input logic [WORD_BITS-1:0] right,
                                                    input logic [COL_BITS-1:0]  s);
        logic [2*WORD_BITS-1:0] both;
        both = {left, right} >> s;
        return both[WORD_BITS-1:0];
    endfunction

endpackage

// File: design/sbwr_rop_core.sv
// Word datapath: funnel shift, edge masking, pattern and raster operation.
module sbwr_rop_core (
    input  sbwr_pkg::sbwr_cfg_t cfg,
    input  sbwr_pkg::sbwr_in_t  item,
    output sbwr_pkg::sbwr_out_t result
);
    import sbwr_pkg::*;

    logic [WORD_BITS-1:0] src;
    logic [WORD_BITS-1:0] opq;
    logic [WORD_BITS-1:0] t;
    logic [WORD_BITS-1:0] p;
    logic [WORD_BITS-1:0] d;
    logic [WORD_BITS-1:0] t_fin;
    logic                 we;

    always_comb begin
        src = funnel(swap_bytes(item.source_word_left), swap_bytes(item.source_word_right),
                     item.shift_amount);
        if (cfg.use_source_mask) begin
            opq = funnel(swap_bytes(item.source_mask_left), swap_bytes(item.source_mask_right),
                         item.shift_amount);
        end else begin
            opq = FULL_WORD;
        end
        if (item.is_first_word) begin
            opq = opq & (FULL_WORD >> item.left_column);
        end
        if (item.is_last_word) begin
            opq = opq & ~(LOW31_MASK >> item.right_column);
        end
        we = |opq;

        // back to memory byte order before the raster op
        t     = swap_bytes(opq & item.pattern_word);
        p     = swap_bytes(src);
        d     = item.dest_word;
        t_fin = t;
        case (cfg.raster_mode)
            ROP_COPY: begin
                d = (d & ~t) | (p & t);
            end
            ROP_INVERT: begin
                d = (d & ~t) | (~p & t);
            end
            ROP_XOR: begin
                d = (d & ~t) | ((d ^ ~p) & t);
            end
            ROP_XNOR: begin
                d = (d & ~t) | ((d ^ p) & t);
            end
            ROP_SET_ALL: begin
                d = d | t;
            end
            ROP_SET_WHERE_SRC: begin
                t_fin = t & p;
                d     = d | t_fin;
            end
            ROP_CLEAR_ALL: begin
                d = d & ~t;
            end
            ROP_CLEAR_NOT_SRC: begin
                t_fin = t & ~p;
                d     = d & ~t_fin;
            end
            default: begin
                d = item.dest_word;
            end
        endcase

        result.write_enable = we;
        if (we) begin
            result.new_dest_word      = d;
            result.new_dest_mask_word = cfg.use_dest_mask ? (item.dest_mask_word | t_fin)
                                                          : item.dest_mask_word;
        end else begin
            result.new_dest_word      = item.dest_word;
            result.new_dest_mask_word = item.dest_mask_word;
        end
    end

endmodule

// File: design/sprite_blit_word_rop.sv
// Top level: config registers, input register, raster-op datapath, result register.
//
// Combines one 32-pixel destination word of a 1-bpp surface with aligned sprite data
// per transfer. Throughput is one word per clock unless m_ready back-pressure stalls the
// pipeline. The input register and the result register sit around the single-pass
// datapath, so each word passes through the input register and then the result register
// before it is valid on m_*. The result register frees up as soon as the consumer takes
// it, so back-pressure only stalls s_ready when both registers hold words.
// raster_mode (0x0), use_source_mask (0x4) and use_dest_mask (0x8) all reset to 0 and
// should only be written while no transfer is in flight.
module sprite_blit_word_rop (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbwr_pkg::sbwr_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output sbwr_pkg::sbwr_out_t m_payload
);
    import sbwr_pkg::*;

    sbwr_cfg_t cfg_reg;
    sbwr_cfg_t cfg_next;
    sbwr_in_t  in_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    sbwr_out_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    sbwr_out_t core_out;
    logic      out_ready;
    logic      cfg_write;
    reg_idx_t  cfg_idx;
    logic      no_write;
    logic      mask_off;
    logic      dest_kept;
    logic      mask_kept;
    logic      mask_grown;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_idx)
                REG_RASTER_MODE: begin
                    cfg_next.raster_mode = rop_mode_t'(pwdata[2:0]);
                end
                REG_USE_SOURCE_MASK: begin
                    cfg_next.use_source_mask = pwdata[0];
                end
                REG_USE_DEST_MASK: begin
                    cfg_next.use_dest_mask = pwdata[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RASTER_MODE: begin
                prdata = {29'd0, cfg_reg.raster_mode};
            end
            REG_USE_SOURCE_MASK: begin
                prdata = {31'd0, cfg_reg.use_source_mask};
            end
            REG_USE_DEST_MASK: begin
                prdata = {31'd0, cfg_reg.use_dest_mask};
            end
            default: begin
                prdata = 32'd0;
            end
        endcase
    end

    // Two-register pipeline; each stage advances when the one after it has room
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '{raster_mode: ROP_COPY, use_source_mask: 1'b0,
                               use_dest_mask: 1'b0};
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        if (in_valid_reg && out_ready) begin
            out_reg <= core_out;
        end
    end

    sbwr_rop_core u_core (
        .cfg    (cfg_reg),
        .item   (in_reg),
        .result (core_out)
    );

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign no_write   = in_valid_reg && !core_out.write_enable;
    assign mask_off   = in_valid_reg && !cfg_reg.use_dest_mask;
    assign dest_kept  = core_out.new_dest_word == in_reg.dest_word;
    assign mask_kept  = core_out.new_dest_mask_word == in_reg.dest_mask_word;
    assign mask_grown = (core_out.new_dest_mask_word & in_reg.dest_mask_word)
                        == in_reg.dest_mask_word;

`include "sprite_blit_word_rop_assert.svh"

    `SBWR_ASSERT_NEXT(a_stage_advance, in_valid_reg && out_ready, out_valid_reg, "word lost")
    `SBWR_ASSERT_SAME(a_no_write_keeps_dest, no_write, dest_kept && mask_kept, "dest changed")
    `SBWR_ASSERT_SAME(a_dest_mask_unused, mask_off, mask_kept, "dest mask updated")
    `SBWR_ASSERT_SAME(a_dest_mask_only_sets, in_valid_reg, mask_grown, "dest mask bit cleared")

endmodule

// File: tb/sv/sprite_blit_word_rop_tb.sv
// Self-checking testbench for the 1bpp sprite blit word raster-op block.
`timescale 1ns / 1ps

module sprite_blit_word_rop_tb;
    import sbwr_pkg::*;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sbwr_in_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    sbwr_out_t   m_payload;

    sbwr_in_t    pending_words[$];
    sbwr_out_t   expected_words[$];

    // Shadow copy of the raster settings used for prediction
    rop_mode_t   cur_mode     = ROP_COPY;
    logic        cur_src_mask = 1'b0;
    logic        cur_dst_mask = 1'b0;

    int          words_offered   = 0;
    int          words_taken     = 0;
    int          results_checked = 0;
    int          writes_seen     = 0;
    int          skips_seen      = 0;
    int          settings_used   = 0;
    int          mismatch_count  = 0;
    int          src_gap         = 0;
    int          sink_gap        = 0;
    logic        steady          = 1'b0;
    logic        stall_start     = 1'b0;
    logic        sink_blocked    = 1'b0;

    sprite_blit_word_rop i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #2 aclk = ~aclk;

    // Byte-swap both words into pixel order, then take 32 bits of {l, r} >> s
    function automatic logic [31:0] align_pair(input logic [31:0] l, input logic [31:0] r,
                                               input logic [4:0] s);
        logic [31:0] l_pix;
        logic [31:0] r_pix;
        logic [63:0] joined;
        l_pix  = {<<8{l}};
        r_pix  = {<<8{r}};
        joined = {l_pix, r_pix};
        return joined[s +: 32];
    endfunction

    function automatic sbwr_out_t rop_word(input sbwr_in_t w);
        logic [31:0] src;
        logic [31:0] opq;
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] d;
        logic [31:0] dm;
        sbwr_out_t   r;
        src = align_pair(w.source_word_left, w.source_word_right, w.shift_amount);
        if (cur_src_mask) begin
            opq = align_pair(w.source_mask_left, w.source_mask_right, w.shift_amount);
        end else begin
            opq = FULL_WORD;
        end
        if (w.is_first_word) begin
            opq &= FULL_WORD >> w.left_column;
        end
        if (w.is_last_word) begin
            opq &= ~(LOW31_MASK >> w.right_column);
        end
        d  = w.dest_word;
        dm = w.dest_mask_word;
        if (opq != '0) begin
            t = {<<8{opq & w.pattern_word}};
            p = {<<8{src}};
            case (cur_mode)
                ROP_COPY:          d = (d & ~t) | (p & t);
                ROP_INVERT:        d = (d & ~t) | (~p & t);
                ROP_XOR:           d = (d & ~t) | ((d ^ ~p) & t);
                ROP_XNOR:          d = (d & ~t) | ((d ^ p) & t);
                ROP_SET_ALL:       d |= t;
                ROP_SET_WHERE_SRC: begin
                    t &= p;
                    d |= t;
                end
                ROP_CLEAR_ALL:     d &= ~t;
                default: begin
                    t &= ~p;
                    d &= ~t;
                end
            endcase
            if (cur_dst_mask) begin
                dm |= t;
            end
        end
        r.new_dest_word      = d;
        r.new_dest_mask_word = dm;
        r.write_enable       = (opq != '0);
        return r;
    endfunction

    function automatic sbwr_in_t random_word();
        sbwr_in_t w;
        w.source_word_left  = $urandom;
        w.source_word_right = $urandom;
        w.source_mask_left  = $urandom;
        w.source_mask_right = $urandom;
        w.shift_amount      = 5'($urandom_range(0, 31));
        w.dest_word         = $urandom;
        w.dest_mask_word    = $urandom;
        w.pattern_word      = $urandom;
        w.is_first_word     = 1'($urandom_range(0, 1));
        w.is_last_word      = 1'($urandom_range(0, 1));
        w.left_column       = 5'($urandom_range(0, 31));
        w.right_column      = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
            0: w.shift_amount = '0;
            1: w.shift_amount = '1;
            2: begin
                w.source_mask_left  = '0;
                w.source_mask_right = '0;
            end
            3: w.pattern_word = '0;
            4: w.pattern_word = '1;
            5: begin
                w.source_mask_left  = $urandom & $urandom & $urandom;
                w.source_mask_right = $urandom & $urandom & $urandom;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] mismatch on result %0d, %s: got %08h want %08h",
                     $realtime, results_checked, what, got, want);
        end
    endtask

    // APB write: setup cycle, then access cycle; pready is tied high
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setup(input rop_mode_t mode, input logic src_mask,
                               input logic dst_mask);
        cfg_write(REG_RASTER_MODE, {29'd0, mode});
        cfg_write(REG_USE_SOURCE_MASK, {31'd0, src_mask});
        cfg_write(REG_USE_DEST_MASK, {31'd0, dst_mask});
        cur_mode     = mode;
        cur_src_mask = src_mask;
        cur_dst_mask = dst_mask;
        settings_used++;
    endtask

    task automatic wait_drained();
        while (words_taken != words_offered || expected_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Input driver: predicts each word at its transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_words.push_back(rop_word(s_payload));
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!steady && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else begin
                    s_valid   <= 1'b1;
                    s_payload <= pending_words.pop_front();
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        sbwr_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected transfer", m_payload.new_dest_word, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_payload.new_dest_word !== want.new_dest_word) begin
                        report_mismatch("new_dest_word", m_payload.new_dest_word,
                                        want.new_dest_word);
                    end
                    if (m_payload.new_dest_mask_word !== want.new_dest_mask_word) begin
                        report_mismatch("new_dest_mask_word", m_payload.new_dest_mask_word,
                                        want.new_dest_mask_word);
                    end
                    if (m_payload.write_enable !== want.write_enable) begin
                        report_mismatch("write_enable", {31'd0, m_payload.write_enable},
                                        {31'd0, want.write_enable});
                    end
                    if (want.write_enable) begin
                        writes_seen++;
                    end else begin
                        skips_seen++;
                    end
                end
                results_checked++;
            end
            if (sink_blocked) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Long back-pressure window so both pipeline stages fill and s_ready drops
    initial begin
        wait (stall_start);
        @(posedge aclk);
        sink_blocked <= 1'b1;
        repeat (80) @(posedge aclk);
        sink_blocked <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("sprite_blit_word_rop_tb NOT OK");
        $finish;
    end

    initial begin
        sbwr_in_t w;
        int       span;
        int       n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners, three per raster mode
        for (int m = 0; m < 8; m++) begin
            apply_setup(rop_mode_t'(m), m[2], m[0]);
            for (int k = 3 * m; k < 3 * m + 3; k++) begin
                w = random_word();
                w.is_first_word = 1'b0;
                w.is_last_word  = 1'b0;
                case (k)
                    0: w = '0;
                    1: w = '1;
                    2: w.shift_amount = '0;
                    3: w.shift_amount = '1;
                    4: begin
                        w.is_first_word = 1'b1;
                        w.left_column   = '0;
                    end
                    5: begin
                        w.is_first_word = 1'b1;
                        w.left_column   = '1;
                    end
                    6: begin
                        w.is_last_word = 1'b1;
                        w.right_column = '0;
                    end
                    7: begin
                        w.is_last_word = 1'b1;
                        w.right_column = '1;
                    end
                    8: begin
                        w = '1;
                        w.left_column  = 5'd5;
                        w.right_column = 5'd20;
                    end
                    9: begin
                        // single-word span whose edges do not overlap
                        w.is_first_word = 1'b1;
                        w.is_last_word  = 1'b1;
                        w.left_column   = 5'd20;
                        w.right_column  = 5'd5;
                    end
                    10: begin
                        w.is_first_word = 1'b1;
                        w.is_last_word  = 1'b1;
                        w.left_column   = 5'd13;
                        w.right_column  = 5'd13;
                    end
                    11: w.pattern_word = '0;
                    12: begin
                        w.source_mask_left  = '0;
                        w.source_mask_right = '0;
                    end
                    13: begin
                        w.source_mask_left  = '1;
                        w.source_mask_right = '1;
                    end
                    14: begin
                        w.dest_word      = '0;
                        w.dest_mask_word = '0;
                    end
                    15: begin
                        w.dest_word      = '1;
                        w.dest_mask_word = '1;
                    end
                    default: begin
                        w.is_first_word = 1'($urandom_range(0, 1));
                        w.is_last_word  = 1'($urandom_range(0, 1));
                    end
                endcase
                pending_words.push_back(w);
                words_offered++;
            end
            wait_drained();
        end

        // Random spans, one register setting per phase
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                apply_setup(ROP_COPY, 1'b0, 1'b0);
            end else if (ph == 1) begin
                apply_setup(ROP_CLEAR_NOT_SRC, 1'b1, 1'b1);
            end else begin
                apply_setup(rop_mode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end
            if (ph == 3) begin
                stall_start = 1'b1;
            end
            if (ph == 9) begin
                steady <= 1'b1;
            end
            n = 0;
            while (n < 92) begin
                span = $urandom_range(1, 5);
                for (int j = 0; j < span; j++) begin
                    w = random_word();
                    w.is_first_word = (j == 0);
                    w.is_last_word  = (j == span - 1);
                    // some broken spans
                    if ($urandom_range(0, 9) == 0) begin
                        w.is_first_word = 1'($urandom_range(0, 1));
                        w.is_last_word  = 1'($urandom_range(0, 1));
                    end
                    pending_words.push_back(w);
                    words_offered++;
                    n++;
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (expected_words.size() != 0) begin
            report_mismatch("results still outstanding", '0, expected_words.size());
        end
        $display("Checked %0d words over %0d register settings: %0d written, %0d skipped.",
                 results_checked, settings_used, writes_seen, skips_seen);
        $display("All eight raster modes, span edges and a long output stall were exercised.");
        if (mismatch_count == 0) begin
            $display("sprite_blit_word_rop_tb OK");
        end else begin
            $display("sprite_blit_word_rop_tb NOT OK");
        end
        $finish;
    end

endmodule
